FILE: design/cmy12rr_pkg.sv
package cmy12rr_pkg;

  localparam int DIM_BITS_DEF = 12;
  localparam int BYTE_W       = 8;
  localparam int CFG_INDEX_W  = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 2'd1;

  localparam logic [BYTE_W-1:0] HI_NIBBLE    = 8'hf0;
  localparam int                NIBBLE_SHIFT = 4;

  localparam logic KIND_COLOUR = 1'b0;
  localparam logic KIND_WHITE  = 1'b1;

  // result queue: room for one item's two results while one more waits
  localparam int BUF_DEPTH = 3;
  localparam int BUF_CNT_W = 2;

  typedef struct packed {
    logic first;
    logic second;
  } rr_push_t;

endpackage

FILE: design/cmy12rr_decode.sv
module cmy12rr_decode
  import cmy12rr_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF,
  localparam int RES_W = DIM_BITS + 3 * BYTE_W + 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]    cfg_data,
  input  logic                   in_accept,
  input  logic [BYTE_W-1:0]      in_byte,
  output rr_push_t               push,
  output logic [RES_W-1:0]       res0,
  output logic [RES_W-1:0]       res1
);

  typedef enum logic [1:0] {PH_WHITE, PH_COUNT, PH_DATA} row_phase_t;
  typedef enum logic [1:0] {PIX_0, PIX_1, PIX_2} pix_phase_t;

  logic [DIM_BITS-1:0] row_width, row_count;
  row_phase_t          row_phase, row_phase_next;
  pix_phase_t          pixel_phase, pixel_phase_next;
  logic [BYTE_W-1:0]   held_byte, held_byte_next;
  logic [BYTE_W-1:0]   colour_left, colour_left_next;
  logic [DIM_BITS-1:0] column, column_next;
  logic [DIM_BITS-1:0] row_index, row_index_next;

  logic [DIM_BITS-1:0] w, b_ext, run, rem, col_inc, row_inc;
  logic [BYTE_W-1:0]   left_dec;
  logic                count_end, img_hit, row_done;
  logic [BYTE_W-1:0]   pc, pm, py;
  logic                r0_kind, r0_end;
  logic [DIM_BITS-1:0] r0_len, r1_len;
  logic [BYTE_W-1:0]   r0_c, r0_m, r0_y;

  assign w        = (row_width == '0) ? DIM_BITS'(1) : row_width;
  assign b_ext    = DIM_BITS'(in_byte);
  assign run      = (b_ext > w) ? w : b_ext;
  assign rem      = (column < w) ? (w - column) : '0;
  assign count_end = (b_ext == w) || (in_byte == '0) || (rem == '0);
  assign col_inc  = column + DIM_BITS'(1);
  assign left_dec = colour_left - BYTE_W'(1);
  assign row_inc  = row_index + DIM_BITS'(1);
  assign img_hit  = (row_inc == '0) || (row_inc >= row_count);

  // unpack the channel nibbles: C1:M1, Y1:C2, M2:Y2
  always_comb begin
    if (pixel_phase == PIX_1) begin
      pc = held_byte & HI_NIBBLE;
      pm = BYTE_W'(held_byte << NIBBLE_SHIFT);
      py = in_byte & HI_NIBBLE;
    end else begin
      pc = BYTE_W'(held_byte << NIBBLE_SHIFT);
      pm = in_byte & HI_NIBBLE;
      py = BYTE_W'(in_byte << NIBBLE_SHIFT);
    end
  end

  always_comb begin
    row_phase_next   = row_phase;
    pixel_phase_next = pixel_phase;
    held_byte_next   = held_byte;
    colour_left_next = colour_left;
    column_next      = column;
    row_index_next   = row_index;
    push             = '0;
    row_done         = 1'b0;
    r0_kind          = KIND_WHITE;
    r0_len           = '0;
    r0_c             = '0;
    r0_m             = '0;
    r0_y             = '0;
    r1_len           = '0;
    if (in_accept) begin
      unique case (row_phase)
        PH_WHITE: begin
          column_next = '0;
          if (run == '0) begin
            row_phase_next = PH_COUNT;
          end else begin
            push.first = 1'b1;
            r0_len     = run;
            if (run >= w) begin
              row_done = 1'b1;
            end else begin
              column_next    = run;
              row_phase_next = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          if (count_end) begin
            push.first = 1'b1;
            r0_len     = (rem == '0) ? DIM_BITS'(1) : rem;
            row_done   = 1'b1;
          end else begin
            // clipped to what is left of the row
            colour_left_next = (b_ext > rem) ? rem[BYTE_W-1:0] : in_byte;
            row_phase_next   = PH_DATA;
            pixel_phase_next = PIX_0;
          end
        end
        PH_DATA: begin
          if (pixel_phase == PIX_1 || pixel_phase == PIX_2) begin
            if (pixel_phase == PIX_1) begin
              held_byte_next   = in_byte;
              pixel_phase_next = PIX_2;
            end else begin
              pixel_phase_next = PIX_0;
            end
            column_next      = col_inc;
            colour_left_next = left_dec;
            push.first       = 1'b1;
            r0_kind          = KIND_COLOUR;
            r0_len           = DIM_BITS'(1);
            r0_c             = pc;
            r0_m             = pm;
            r0_y             = py;
            if (left_dec == '0) begin
              row_done = 1'b1;
              if (col_inc < w) begin
                // colour run stops short: rest of row is white
                push.second = 1'b1;
                r1_len      = w - col_inc;
              end
            end
          end else begin
            held_byte_next   = in_byte;
            pixel_phase_next = PIX_1;
          end
        end
        default: ;
      endcase
      if (row_done) begin
        row_phase_next   = PH_WHITE;
        pixel_phase_next = PIX_0;
        colour_left_next = '0;
        column_next      = '0;
        row_index_next   = img_hit ? '0 : row_inc;
      end
    end
    r0_end = row_done & ~push.second;
  end

  assign res0 = {r0_end & img_hit, r0_end, r0_kind, r0_y, r0_m, r0_c, r0_len};
  assign res1 = {img_hit, 1'b1, KIND_WHITE, {(3 * BYTE_W){1'b0}}, r1_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= DIM_BITS'(1);
      row_count   <= DIM_BITS'(1);
      row_phase   <= PH_WHITE;
      pixel_phase <= PIX_0;
      held_byte   <= '0;
      colour_left <= '0;
      column      <= '0;
      row_index   <= '0;
    end else if (cfg_we && (cfg_index == REG_ROW_WIDTH || cfg_index == REG_ROW_COUNT)) begin
      if (cfg_index == REG_ROW_WIDTH) begin
        row_width <= cfg_data;
      end else begin
        row_count <= cfg_data;
      end
      // any register write starts a new image
      row_phase   <= PH_WHITE;
      pixel_phase <= PIX_0;
      held_byte   <= '0;
      colour_left <= '0;
      column      <= '0;
      row_index   <= '0;
    end else begin
      row_phase   <= row_phase_next;
      pixel_phase <= pixel_phase_next;
      held_byte   <= held_byte_next;
      colour_left <= colour_left_next;
      column      <= column_next;
      row_index   <= row_index_next;
    end
  end

endmodule

FILE: design/cmy12rr_out_buf.sv
module cmy12rr_out_buf
  import cmy12rr_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  rr_push_t         push,
  input  logic [WIDTH-1:0] din0,
  input  logic [WIDTH-1:0] din1,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0]     q      [BUF_DEPTH];
  logic [WIDTH-1:0]     q_next [BUF_DEPTH];
  logic [BUF_CNT_W-1:0] count, count_next, base;
  logic                 pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid & out_ready;
  assign dout      = q[0];
  // two free slots needed: an item may leave two results
  assign in_ready  = (count <= BUF_CNT_W'(1));
  assign base      = count - BUF_CNT_W'(pop);
  assign count_next = base + BUF_CNT_W'(push.first) + BUF_CNT_W'(push.second);

  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      q_next[i] = (pop && i < BUF_DEPTH - 1) ? q[(i + 1) % BUF_DEPTH] : q[i];
      if (push.first && base == BUF_CNT_W'(i)) begin
        q_next[i] = din0;
      end
      if (push.second && base + BUF_CNT_W'(1) == BUF_CNT_W'(i)) begin
        q_next[i] = din1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    for (int i = 0; i < BUF_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

FILE: design/cmy12_row_run_decoder_unit.sv
// Row run-length decoder for a 12-bit CMY preview image.
// Input stream (s_*): one compressed byte per item in s_tdata. Each row is a
// white count byte, then (if the row is not full) a colour count byte, then
// colour pixels packed two per three bytes.
// Output stream (m_*): one result per item, a colour pixel (tuser[0] = 0,
// run_length 1) or a white run (tuser[0] = 1, colours zero). m_tlast marks
// the result that completes a row, tuser[1] the one that completes the image.
// Config channel (cfg_*): index 0 row_width, 1 row_count; always ready. A
// write also restarts decoding at the top of an image. Write only when idle.
// Results enter the result queue when their byte is accepted; m_* shows the queue head.
// Throughput: one byte per cycle while s_tready is high. A byte that ends a
// colour run short of the row end yields two results; the three-entry result
// queue then holds s_tready low while the extra result drains.
// When m_tready is low the queue fills and s_tready drops once fewer than two
// entries are free; nothing is lost.
// Reset (rst, synchronous): width and count return to 1, queue empties,
// decoding starts at the white count of the first row.
module cmy12_row_run_decoder_unit
  import cmy12rr_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF,
  localparam int OUT_W = ((DIM_BITS + 3 * BYTE_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,   // data_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // run_length, cyan, magenta, yellow, zero fill
  output logic                   m_tlast,   // row_end
  output logic [1:0]             m_tuser,   // kind, image_end
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]    cfg_data
);

  localparam int RES_W = DIM_BITS + 3 * BYTE_W + 3;
  localparam int PAY_W = DIM_BITS + 3 * BYTE_W;

  rr_push_t         push;
  logic [RES_W-1:0] res0, res1, head;
  logic             in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid & s_tready;

  cmy12rr_decode #(.DIM_BITS(DIM_BITS)) u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_byte   (s_tdata),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  cmy12rr_out_buf #(.WIDTH(RES_W)) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din0      (res0),
    .din1      (res1),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (head)
  );

  // result word: {image_end, row_end, kind, yellow, magenta, cyan, run_length}
  assign m_tdata = OUT_W'(head[PAY_W-1:0]);
  assign m_tuser = {head[RES_W-1], head[PAY_W]};
  assign m_tlast = head[PAY_W+1];

endmodule

FILE: design/cmy12rr_checker.sv
module cmy12rr_checker
  import cmy12rr_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF,
  localparam int OUT_W = ((DIM_BITS + 3 * BYTE_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast,
  input logic [1:0]       m_tuser
);

  localparam int PAY_W = DIM_BITS + 3 * BYTE_W;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled item changed");

  a_image_end_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("image end without row end");

  a_white_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] == KIND_WHITE |->
      m_tdata[PAY_W-1:DIM_BITS] == '0 && m_tdata[DIM_BITS-1:0] != '0)
    else $error("white run with colour or zero length");

  a_colour_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] == KIND_COLOUR |-> m_tdata[DIM_BITS-1:0] == DIM_BITS'(1))
    else $error("colour item with length other than one");

endmodule

bind cmy12_row_run_decoder_unit cmy12rr_checker #(.DIM_BITS(DIM_BITS)) u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
